### design/cppd_pkg.sv
package cppd_pkg;

  // Byte that closes a column.
  localparam logic [7:0] POST_END = 8'hFF;

  // Columns at or above this bound are clipped.
  localparam int unsigned MAX_DIM = 4096;

  // Register indexes of the configuration port.
  localparam logic [0:0] CFG_HEIGHT = 1'b0;
  localparam logic [0:0] CFG_ALPHA  = 1'b1;

  // Input function codes.
  localparam logic FUNC_PALETTE = 1'b0;
  localparam logic FUNC_DATA    = 1'b1;

  typedef enum logic [2:0] {
    PH_TOP  = 3'd0,
    PH_LEN  = 3'd1,
    PH_PAD  = 3'd2,
    PH_DATA = 3'd3,
    PH_TAIL = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_END   = 2'd1,
    KIND_CLIP  = 2'd2
  } kind_t;

  // Result produced by the parser for one data byte.
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [11:0] x;
    logic [8:0]  y;
  } cppd_res_t;

endpackage

### design/cppd_palette.sv
module cppd_palette #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [7:0]  wr_addr,
  input  logic [23:0] wr_data,
  input  logic        rd_en,
  input  logic [7:0]  rd_addr,
  output logic [23:0] rd_data
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [23:0] mem [ENTRIES];
  logic [23:0] q;
  logic        rd_ok;
  logic        wr_in_range;
  logic        rd_in_range;

  // Indexes beyond the table are ignored on write and read as black.
  assign wr_in_range = ({1'b0, wr_addr} < 9'(ENTRIES));
  assign rd_in_range = ({1'b0, rd_addr} < 9'(ENTRIES));

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_addr[IDX_W-1:0]] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q     <= mem[rd_addr[IDX_W-1:0]];
      rd_ok <= rd_in_range;
    end
  end

  assign rd_data = rd_ok ? q : 24'd0;

endmodule

### design/cppd_parser.sv
module cppd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_fire,
  input  logic [11:0]         column,
  input  logic [7:0]          data_byte,
  input  logic [11:0]         picture_height,
  output cppd_pkg::cppd_res_t res
);

  cppd_pkg::phase_t phase, phase_next;
  logic [7:0]       top_row, top_row_next;
  logic [7:0]       remaining, remaining_next;
  logic [7:0]       position, position_next;
  logic [8:0]       row;
  logic             clip;

  assign row  = {1'b0, top_row} + {1'b0, position};
  assign clip = ({3'b000, row} >= picture_height) ||
                ({5'd0, column} >= 17'(cppd_pkg::MAX_DIM));

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= cppd_pkg::PH_TOP;
      top_row   <= 8'd0;
      remaining <= 8'd0;
      position  <= 8'd0;
    end else if (data_fire) begin
      phase     <= phase_next;
      top_row   <= top_row_next;
      remaining <= remaining_next;
      position  <= position_next;
    end
  end

  // Next state of the post parser.
  always_comb begin
    phase_next     = phase;
    top_row_next   = top_row;
    remaining_next = remaining;
    position_next  = position;
    unique case (phase)
      cppd_pkg::PH_LEN: begin
        remaining_next = data_byte;
        position_next  = 8'd0;
        phase_next     = cppd_pkg::PH_PAD;
      end
      cppd_pkg::PH_PAD: begin
        phase_next = (remaining != 8'd0) ? cppd_pkg::PH_DATA : cppd_pkg::PH_TAIL;
      end
      cppd_pkg::PH_DATA: begin
        position_next  = position + 8'd1;
        remaining_next = remaining - 8'd1;
        if (remaining == 8'd1) begin
          phase_next = cppd_pkg::PH_TAIL;
        end
      end
      cppd_pkg::PH_TAIL: begin
        phase_next = cppd_pkg::PH_TOP;
      end
      default: begin
        if (data_byte == cppd_pkg::POST_END) begin
          phase_next = cppd_pkg::PH_TOP;
        end else begin
          top_row_next = data_byte;
          phase_next   = cppd_pkg::PH_LEN;
        end
      end
    endcase
  end

  // Result for the current byte: a pixel inside a post or the column end.
  always_comb begin
    res.valid = 1'b0;
    res.kind  = cppd_pkg::KIND_PIXEL;
    res.x     = column;
    res.y     = 9'd0;
    unique case (phase)
      cppd_pkg::PH_LEN, cppd_pkg::PH_PAD, cppd_pkg::PH_TAIL: begin
        res.valid = 1'b0;
      end
      cppd_pkg::PH_DATA: begin
        res.valid = 1'b1;
        res.kind  = clip ? cppd_pkg::KIND_CLIP : cppd_pkg::KIND_PIXEL;
        res.y     = row;
      end
      default: begin
        if (data_byte == cppd_pkg::POST_END) begin
          res.valid = 1'b1;
          res.kind  = cppd_pkg::KIND_END;
        end
      end
    endcase
  end

endmodule

### design/column_post_picture_decoder.sv
// Column-post picture decoder. Feed palette writes (func 0) first, then the
// bytes of each column in order (func 1); every palette index byte of a post
// yields one pixel transfer and the 0xFF terminator yields a column-end
// transfer. One item is taken every cycle while in_stall is low; a result
// passes the synchronous palette read, then the output register. The palette
// memory is written at the transfer edge of a palette item, so a colour may
// be used by the very next byte. The user must write configuration through
// cfg_write only while no item is in flight; the block does not enforce it.
module column_post_picture_decoder #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [11:0] column,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  palette_red,
  input  logic [7:0]  palette_green,
  input  logic [7:0]  palette_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [11:0] pixel_x,
  output logic [8:0]  pixel_y,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha
);

  logic [11:0]         picture_height;
  logic [7:0]          alpha_value;
  logic                in_fire;
  logic                data_fire;
  logic                pal_wr;
  cppd_pkg::cppd_res_t res;
  cppd_pkg::cppd_res_t s1;
  logic                s1_adv;
  logic [23:0]         rgb;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      picture_height <= 12'd1;
      alpha_value    <= 8'd255;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cppd_pkg::CFG_HEIGHT: picture_height <= cfg_data;
        cppd_pkg::CFG_ALPHA:  alpha_value    <= cfg_data[7:0];
        default:              alpha_value    <= alpha_value;
      endcase
    end
  end

  // Input transfer and stage advance.
  assign s1_adv    = !out_valid || !out_stall;
  assign in_stall  = s1.valid && !s1_adv;
  assign in_fire   = in_valid && !in_stall;
  assign data_fire = in_fire && (func == cppd_pkg::FUNC_DATA);
  assign pal_wr    = in_fire && (func == cppd_pkg::FUNC_PALETTE);

  cppd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .data_fire      (data_fire),
    .column         (column),
    .data_byte      (data_byte),
    .picture_height (picture_height),
    .res            (res)
  );

  cppd_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (pal_wr),
    .wr_addr (data_byte),
    .wr_data ({palette_red, palette_green, palette_blue}),
    .rd_en   (data_fire),
    .rd_addr (data_byte),
    .rd_data (rgb)
  );

  // Read stage: holds the result while the palette read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (in_fire) begin
      s1.valid <= data_fire && res.valid;
    end else if (s1_adv) begin
      s1.valid <= 1'b0;
    end
    if (data_fire) begin
      s1.kind <= res.kind;
      s1.x    <= res.x;
      s1.y    <= res.y;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.valid) begin
      kind    <= s1.kind;
      pixel_x <= s1.x;
      if (s1.kind == cppd_pkg::KIND_END) begin
        pixel_y <= 9'd0;
        red     <= 8'd0;
        green   <= 8'd0;
        blue    <= 8'd0;
        alpha   <= 8'd0;
      end else begin
        pixel_y <= s1.y;
        red     <= rgb[23:16];
        green   <= rgb[15:8];
        blue    <= rgb[7:0];
        alpha   <= alpha_value;
      end
    end
  end

endmodule

### design/cppd_checker.sv
module cppd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [11:0] pixel_x,
  input logic [8:0]  pixel_y,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic [7:0]  alpha
);

  // A stalled result stays offered unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(pixel_x) &&
      $stable(pixel_y) && $stable(red) && $stable(green) && $stable(blue) &&
      $stable(alpha))
    else $error("stalled result changed");

  // No result is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // Only the three defined result kinds appear.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == cppd_pkg::KIND_PIXEL) || (kind == cppd_pkg::KIND_END) ||
      (kind == cppd_pkg::KIND_CLIP))
    else $error("undefined result kind");

  // A column end carries no row, colour or alpha.
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == cppd_pkg::KIND_END) |->
      (pixel_y == 9'd0) && (red == 8'd0) && (green == 8'd0) && (blue == 8'd0) &&
      (alpha == 8'd0))
    else $error("column end with pixel data");

endmodule

bind column_post_picture_decoder cppd_checker u_cppd_checker (.*);

### test/column_post_picture_decoder_checker.sv
module column_post_picture_decoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        func,
  input  logic [11:0] column,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  palette_red,
  input  logic [7:0]  palette_green,
  input  logic [7:0]  palette_blue,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  kind,
  input  logic [11:0] pixel_x,
  input  logic [8:0]  pixel_y,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  output int          pending,
  output int          fails
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cppd_pkg::kind_t kind;
    logic [11:0]     x;
    logic [8:0]      y;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      alpha;
  } pixel_result_t;

  // Own copy of the registers and of the column parser.
  logic [11:0]      rows_shown;
  logic [7:0]       alpha_now;
  cppd_pkg::phase_t parse_at;
  logic [7:0]       post_top;
  logic [7:0]       post_left;
  logic [7:0]       post_place;
  logic [23:0]      colour_map [256];
  pixel_result_t    awaited_pixels [$];
  int               errors = 0;

  function automatic string show(pixel_result_t p);
    return $sformatf("kind %0d x %0d y %0d rgba %02h%02h%02h%02h",
                     p.kind, p.x, p.y, p.red, p.green, p.blue, p.alpha);
  endfunction

  always @(posedge clk) begin : watch
    pixel_result_t want;
    pixel_result_t got;
    logic [8:0]    row;
    logic [23:0]   rgb;
    logic          makes_result;
    if (rst) begin
      rows_shown = 12'd1;
      alpha_now  = 8'd255;
      parse_at   = cppd_pkg::PH_TOP;
      post_top   = 8'd0;
      post_left  = 8'd0;
      post_place = 8'd0;
      awaited_pixels.delete();
    end else begin
      // Register writes only happen while nothing is in flight.
      if (cfg_write) begin
        case (cfg_index)
          cppd_pkg::CFG_HEIGHT: rows_shown = cfg_data;
          cppd_pkg::CFG_ALPHA:  alpha_now  = cfg_data[7:0];
          default: ;
        endcase
      end

      // Work out what an accepted input transfer should produce.
      if (in_valid && !in_stall) begin
        if (func == cppd_pkg::FUNC_PALETTE) begin
          colour_map[data_byte] = {palette_red, palette_green, palette_blue};
        end else begin
          makes_result = 1'b0;
          want = '0;
          case (parse_at)
            cppd_pkg::PH_LEN: begin
              post_left  = data_byte;
              post_place = 8'd0;
              parse_at   = cppd_pkg::PH_PAD;
            end
            cppd_pkg::PH_PAD: begin
              parse_at = (post_left != 8'd0) ? cppd_pkg::PH_DATA : cppd_pkg::PH_TAIL;
            end
            cppd_pkg::PH_DATA: begin
              row = {1'b0, post_top} + {1'b0, post_place};
              rgb = colour_map[data_byte];
              want.kind  = (({3'b000, row} >= rows_shown) ||
                            ({20'd0, column} >= cppd_pkg::MAX_DIM)) ?
                           cppd_pkg::KIND_CLIP : cppd_pkg::KIND_PIXEL;
              want.x     = column;
              want.y     = row;
              want.red   = rgb[23:16];
              want.green = rgb[15:8];
              want.blue  = rgb[7:0];
              want.alpha = alpha_now;
              makes_result = 1'b1;
              post_place = post_place + 8'd1;
              post_left  = post_left - 8'd1;
              if (post_left == 8'd0) parse_at = cppd_pkg::PH_TAIL;
            end
            cppd_pkg::PH_TAIL: parse_at = cppd_pkg::PH_TOP;
            default: begin
              // Anything else waits for a top-row byte or the terminator.
              if (data_byte == cppd_pkg::POST_END) begin
                want.kind = cppd_pkg::KIND_END;
                want.x = column;
                makes_result = 1'b1;
                parse_at = cppd_pkg::PH_TOP;
              end else begin
                post_top = data_byte;
                parse_at = cppd_pkg::PH_LEN;
              end
            end
          endcase
          if (makes_result) awaited_pixels.push_back(want);
        end
      end

      // Compare each output transfer with the oldest expectation.
      if (out_valid && !out_stall) begin
        got.kind  = cppd_pkg::kind_t'(kind);
        got.x     = pixel_x;
        got.y     = pixel_y;
        got.red   = red;
        got.green = green;
        got.blue  = blue;
        got.alpha = alpha;
        if (awaited_pixels.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: %s", show(got));
        end else begin
          want = awaited_pixels.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected %s, got %s", show(want), show(got));
            end
          end
        end
      end
    end
    pending <= awaited_pixels.size();
    fails <= errors;
  end

endmodule

### test/column_post_picture_decoder_tb.sv
module column_post_picture_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [0:0]  cfg_index = cppd_pkg::CFG_HEIGHT;
  logic [11:0] cfg_data = 12'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = cppd_pkg::FUNC_DATA;
  logic [11:0] column = 12'd0;
  logic [7:0]  data_byte = 8'd0;
  logic [7:0]  palette_red = 8'd0;
  logic [7:0]  palette_green = 8'd0;
  logic [7:0]  palette_blue = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [11:0] pixel_x;
  logic [8:0]  pixel_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  int          pending;
  int          fails;

  // Stimulus bookkeeping: palette entries written so far and items sent.
  bit          colour_known [256];
  logic [7:0]  known_colours [$];
  int          sent = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;

  column_post_picture_decoder dut (.*);
  column_post_picture_decoder_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Output side holds off in random bursts until the closing stretch.
  always @(posedge clk) begin : receiver
    if (stall_left > 0) stall_left = stall_left - 1;
    else if (!calm && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 16);
    out_stall <= (stall_left > 0);
  end

  // Present one item and hold it until the transfer takes place.
  task automatic send(input logic f, input logic [11:0] col, input logic [7:0] b,
                      input logic [23:0] rgb);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    column <= col;
    data_byte <= b;
    {palette_red, palette_green, palette_blue} <= rgb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_byte(input logic [11:0] col, input logic [7:0] b);
    send(cppd_pkg::FUNC_DATA, col, b, 24'($urandom));
  endtask

  task automatic set_colour(input logic [7:0] idx, input logic [23:0] rgb);
    send(cppd_pkg::FUNC_PALETTE, 12'($urandom), idx, rgb);
    if (!colour_known[idx]) begin
      colour_known[idx] = 1'b1;
      known_colours.push_back(idx);
    end
  endtask

  function automatic logic [7:0] pick_index();
    return known_colours[$urandom_range(0, known_colours.size() - 1)];
  endfunction

  function automatic logic [11:0] random_column();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [7:0] random_top();
    return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 30)) :
                                        8'($urandom_range(0, 254));
  endfunction

  function automatic logic [7:0] random_length();
    return ($urandom_range(0, 7) != 0) ? 8'($urandom_range(0, 6)) :
                                         8'($urandom_range(7, 40));
  endfunction

  // One post; now and then a palette entry changes between its indices.
  task automatic send_post(input logic [11:0] col, input logic [7:0] top,
                           input logic [7:0] len);
    send_byte(col, top);
    send_byte(col, len);
    send_byte(col, 8'($urandom));
    for (int i = 0; i < int'(len); i++) begin
      if ($urandom_range(0, 15) == 0) set_colour(8'($urandom), 24'($urandom));
      send_byte(col, pick_index());
    end
    send_byte(col, 8'($urandom));
  endtask

  task automatic send_column(input logic [11:0] col, input int posts);
    for (int i = 0; i < posts; i++) send_post(col, random_top(), random_length());
    send_byte(col, cppd_pkg::POST_END);
  endtask

  // A post cut short, followed by whatever comes next.
  task automatic send_broken_post(input logic [11:0] col);
    logic [7:0] len;
    len = 8'($urandom_range(1, 8));
    send_byte(col, random_top());
    send_byte(col, len);
    send_byte(col, 8'($urandom));
    repeat ($urandom_range(0, int'(len) - 1)) send_byte(col, pick_index());
  endtask

  // Wait for every expected result and then for the pipeline to drain.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [11:0] height, input logic [7:0] alpha_byte);
    logic [3:0] spare;
    spare = 4'($urandom);
    cfg_write <= 1'b1;
    cfg_index <= cppd_pkg::CFG_HEIGHT;
    cfg_data <= height;
    @(posedge clk);
    cfg_index <= cppd_pkg::CFG_ALPHA;
    cfg_data <= {spare, alpha_byte};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0]  order [256];
    logic [7:0]  swap;
    logic [11:0] heights [7];
    logic [7:0]  alphas [7];
    int          j;
    int          mark;
    int          choice;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: only row 0 fits.
    set_colour(8'd0, 24'hFFFFFF);
    set_colour(8'd255, 24'h000000);
    set_colour(8'd128, 24'hA55AC3);
    // Column 0: a two-pixel post, then a zero-length post, then the end.
    send_byte(12'd0, 8'd0);
    send_byte(12'd0, 8'd2);
    send_byte(12'd0, 8'h00);
    send_byte(12'd0, 8'd0);
    send_byte(12'd0, 8'd255);
    send_byte(12'd0, 8'hFF);
    send_byte(12'd0, 8'd5);
    send_byte(12'd0, 8'd0);
    send_byte(12'd0, 8'hFF);
    send_byte(12'd0, 8'h00);
    send_byte(12'd0, cppd_pkg::POST_END);
    // Last column, highest top row.
    send_byte(12'hFFF, 8'd254);
    send_byte(12'hFFF, 8'd1);
    send_byte(12'hFFF, 8'h00);
    send_byte(12'hFFF, 8'd128);
    send_byte(12'hFFF, 8'hFF);
    send_byte(12'hFFF, cppd_pkg::POST_END);

    // Fill the whole palette in shuffled order.
    settle();
    configure(12'd4095, 8'd0);
    for (int i = 0; i < 256; i++) order[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    for (int i = 0; i < 256; i++) set_colour(order[i], 24'($urandom));

    heights = '{12'd0, 12'd4095, 12'd1, 12'd300, 12'd24, 12'd0, 12'd0};
    heights[5] = 12'($urandom_range(1, 4095));
    heights[6] = 12'($urandom_range(2, 509));
    alphas = '{8'd255, 8'd0, 8'd0, 8'd128, 8'd255, 8'd0, 8'd0};
    alphas[2] = 8'($urandom);
    alphas[5] = 8'($urandom);
    alphas[6] = 8'($urandom);

    // Random part, one register setting per phase; the last one runs flat out.
    for (int ph = 0; ph < 7; ph++) begin
      settle();
      configure(heights[ph], alphas[ph]);
      if (ph == 6) calm = 1'b1;
      if (ph == 3) begin
        // Longest post from the highest top row crosses the clipping line.
        send_post(random_column(), 8'd254, 8'd255);
        send_byte(random_column(), cppd_pkg::POST_END);
      end
      mark = sent;
      while (sent - mark < 70) begin
        choice = $urandom_range(0, 19);
        if (choice < 15) send_column(random_column(), $urandom_range(0, 3));
        else if (choice < 17) set_colour(8'($urandom), 24'($urandom));
        else if (choice < 19) send_broken_post(random_column());
        else repeat ($urandom_range(1, 6)) send_byte(random_column(), 8'($urandom));
      end
    end

    settle();
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
